/* hw/rtl/tpsl_pkg.sv */
// tpsl_pkg: shared constants, types and the divide step for the sensor linearizer
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package tpsl_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned NumBits    = SampleBits + 16;
  localparam int unsigned LuxBits    = 16;
  localparam int unsigned MoistBits  = 10;
  localparam int unsigned InDataBits = ((2 * SampleBits + 7) / 8) * 8;
  localparam int unsigned OutDataBits = ((MoistBits + LuxBits + 7) / 8) * 8;

  localparam logic [SampleBits-1:0] FullScale = {SampleBits{1'b1}};
  localparam logic [9:0]            MoistMax  = 10'd1000;
  localparam logic [LuxBits-1:0]    LuxCeilReset = 16'd1000;

  localparam logic [2:0] RegSoilDry     = 3'd0;
  localparam logic [2:0] RegSoilWet     = 3'd1;
  localparam logic [2:0] RegSoilCal     = 3'd2;
  localparam logic [2:0] RegLightDark   = 3'd3;
  localparam logic [2:0] RegLightBright = 3'd4;
  localparam logic [2:0] RegLuxFloor    = 3'd5;
  localparam logic [2:0] RegLuxCeil     = 3'd6;
  localparam logic [2:0] RegLightCal    = 3'd7;

  typedef struct packed {
    logic [SampleBits-1:0] rem;
    logic [NumBits-1:0]    num;
    logic [SampleBits-1:0] div;
    logic                  neg;
  } lane_t;

  // light_cal: the light quotient is an offset from the lux floor
  typedef struct packed {
    lane_t soil;
    lane_t light;
    logic  light_cal;
  } stage_t;

  typedef struct packed {
    logic [LuxBits-1:0] lux_floor;
    logic [LuxBits-1:0] lux_ceil;
  } lux_cfg_t;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic lane_t div_step(lane_t x);
    logic [SampleBits:0] sh;
    logic [SampleBits:0] tr;
    lane_t               y;
    y  = x;
    sh = {x.rem, x.num[NumBits-1]};
    tr = sh - {1'b0, x.div};
    if (!tr[SampleBits]) begin
      y.rem = tr[SampleBits-1:0];
      y.num = {x.num[NumBits-2:0], 1'b1};
    end else begin
      y.rem = sh[SampleBits-1:0];
      y.num = {x.num[NumBits-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tpsl_front.sv */
// tpsl_front: picks the mapping, forms numerators and divisors, registers the first stage
// depends on tpsl_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpsl_front import tpsl_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [SampleBits-1:0] soil_i,
  input  wire logic [SampleBits-1:0] light_i,
  input  wire logic [SampleBits-1:0] soil_dry_i,
  input  wire logic [SampleBits-1:0] soil_wet_i,
  input  wire logic                  soil_cal_i,
  input  wire logic [SampleBits-1:0] light_dark_i,
  input  wire logic [SampleBits-1:0] light_bright_i,
  input  wire lux_cfg_t              lux_cfg_i,
  input  wire logic                  light_cal_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output stage_t                     out_o
);

  logic                        valid_q;
  stage_t                      st_q, st_d;
  logic signed [SampleBits:0]    soil_diff, soil_span;
  logic signed [SampleBits+11:0] soil_prod;
  logic [SampleBits+11:0]        soil_mag;
  logic [SampleBits-1:0]         soil_div_mag;
  logic [SampleBits+9:0]         soil_def;
  logic signed [SampleBits:0]    light_diff;
  logic signed [LuxBits:0]       lux_span;
  logic signed [SampleBits+17:0] light_prod;
  logic [SampleBits+17:0]        light_mag;
  logic [SampleBits+9:0]         light_def;
  logic [SampleBits-1:0]         light_inv;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = st_q;

  always_comb begin
    soil_diff    = $signed({1'b0, soil_i}) - $signed({1'b0, soil_wet_i});
    soil_span    = $signed({1'b0, soil_dry_i}) - $signed({1'b0, soil_wet_i});
    soil_prod    = soil_diff * $signed(11'sd1000);
    soil_mag     = soil_prod[SampleBits+11] ? -soil_prod : soil_prod;
    soil_div_mag = soil_span[SampleBits] ? SampleBits'(-soil_span)
                                         : soil_span[SampleBits-1:0];
    soil_def     = soil_i * 10'd1000;
    light_diff   = $signed({1'b0, light_dark_i}) - $signed({1'b0, light_i});
    lux_span     = $signed({1'b0, lux_cfg_i.lux_ceil}) - $signed({1'b0, lux_cfg_i.lux_floor});
    light_prod   = light_diff * lux_span;
    light_mag    = light_prod[SampleBits+17] ? -light_prod : light_prod;
    light_inv    = FullScale - light_i;
    light_def    = light_inv * 10'd1000;

    st_d = '0;
    if (soil_cal_i && (soil_dry_i != soil_wet_i)) begin
      st_d.soil.num = NumBits'(soil_mag);
      st_d.soil.div = soil_div_mag;
      st_d.soil.neg = soil_prod[SampleBits+11] ^ soil_span[SampleBits];
    end else begin
      st_d.soil.num = NumBits'(soil_def);
      st_d.soil.div = FullScale;
    end
    if (light_cal_i && (light_dark_i > light_bright_i)) begin
      st_d.light.num = light_mag[NumBits-1:0];
      st_d.light.div = light_dark_i - light_bright_i;
      st_d.light.neg = light_prod[SampleBits+17];
      st_d.light_cal = 1'b1;
    end else begin
      st_d.light.num = NumBits'(light_def);
      st_d.light.div = FullScale;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tpsl_cell.sv */
// tpsl_cell: one quotient bit for both channels, registered toward the next cell
// depends on tpsl_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpsl_cell import tpsl_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire stage_t in_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output stage_t      out_o
);

  logic   valid_q;
  stage_t st_q, st_d;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = st_q;

  always_comb begin
    st_d       = in_i;
    st_d.soil  = div_step(in_i.soil);
    st_d.light = div_step(in_i.light);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tpsl_back.sv */
// tpsl_back: applies quotient signs, saturates moisture, clamps lux, holds the output item
// depends on tpsl_pkg
`timescale 1ns / 1ps
`default_nettype none
module tpsl_back import tpsl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire stage_t    in_i,
  input  wire lux_cfg_t  lux_cfg_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [MoistBits-1:0] moist_o,
  output logic [LuxBits-1:0]   lux_o
);

  logic                     valid_q;
  logic [MoistBits-1:0]     moist_q, moist_d;
  logic [LuxBits-1:0]       lux_q, lux_d;
  logic signed [NumBits+1:0] soil_q_s, light_q_s, moist_s, lux_s, lo_s, hi_s;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign moist_o     = moist_q;
  assign lux_o       = lux_q;

  always_comb begin
    soil_q_s  = $signed({2'b00, in_i.soil.num});
    light_q_s = $signed({2'b00, in_i.light.num});
    if (in_i.soil.neg) soil_q_s = -soil_q_s;
    if (in_i.light.neg) light_q_s = -light_q_s;
    lo_s = $signed({{(NumBits+2-LuxBits){1'b0}}, lux_cfg_i.lux_floor});
    hi_s = $signed({{(NumBits+2-LuxBits){1'b0}}, lux_cfg_i.lux_ceil});

    moist_s = $signed({{(NumBits+2-MoistBits){1'b0}}, MoistMax}) - soil_q_s;
    if (moist_s < 0) begin
      moist_d = '0;
    end else if (moist_s > $signed({{(NumBits+2-MoistBits){1'b0}}, MoistMax})) begin
      moist_d = MoistMax;
    end else begin
      moist_d = moist_s[MoistBits-1:0];
    end

    lux_s = light_q_s;
    if (in_i.light_cal) lux_s = lo_s + light_q_s;
    if (lux_s < lo_s) lux_s = lo_s;
    if (lux_s > hi_s) lux_s = hi_s;
    lux_d = lux_s[LuxBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      moist_q <= moist_d;
      lux_q   <= lux_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/two_point_sensor_linearizer.sv */
// two_point_sensor_linearizer: top level, configuration registers and the divider chain
// depends on tpsl_pkg, tpsl_front, tpsl_cell, tpsl_back
//
// Maps a soil/light sample pair to moisture in tenths of a percent and light in lux.
// One item is accepted every clock cycle unless the output stalls; each item passes
// through one setup stage with the multipliers, one divider cell per quotient bit,
// and the clamp/output register. Every stage holds its item only while the next
// one is full, so bubbles close up. The user must write configuration only while
// no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module two_point_sensor_linearizer import tpsl_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [2:0]             cfg_idx_i,
  input  wire logic [LuxBits-1:0]     cfg_data_i,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [InDataBits-1:0]  s_axis_tdata,  // soil_sample, light_sample
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OutDataBits-1:0]      m_axis_tdata   // moisture_tenths, light_lux
);

  logic [SampleBits-1:0] soil_dry_q, soil_wet_q, light_dark_q, light_bright_q;
  logic                  soil_cal_q, light_cal_q;
  lux_cfg_t              lux_cfg_q;
  stage_t                st [NumBits+1];
  logic                  vld [NumBits+1];
  logic                  rdy [NumBits+1];
  logic [MoistBits-1:0]  moist;
  logic [LuxBits-1:0]    lux;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soil_dry_q         <= FullScale;
      soil_wet_q         <= '0;
      soil_cal_q         <= 1'b0;
      light_dark_q       <= FullScale;
      light_bright_q     <= '0;
      lux_cfg_q.lux_floor <= '0;
      lux_cfg_q.lux_ceil  <= LuxCeilReset;
      light_cal_q        <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSoilDry:     soil_dry_q          <= cfg_data_i[SampleBits-1:0];
        RegSoilWet:     soil_wet_q          <= cfg_data_i[SampleBits-1:0];
        RegSoilCal:     soil_cal_q          <= cfg_data_i[0];
        RegLightDark:   light_dark_q        <= cfg_data_i[SampleBits-1:0];
        RegLightBright: light_bright_q      <= cfg_data_i[SampleBits-1:0];
        RegLuxFloor:    lux_cfg_q.lux_floor <= cfg_data_i;
        RegLuxCeil:     lux_cfg_q.lux_ceil  <= cfg_data_i;
        RegLightCal:    light_cal_q         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tpsl_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .soil_i         (s_axis_tdata[SampleBits-1:0]),
    .light_i        (s_axis_tdata[2*SampleBits-1:SampleBits]),
    .soil_dry_i     (soil_dry_q),
    .soil_wet_i     (soil_wet_q),
    .soil_cal_i     (soil_cal_q),
    .light_dark_i   (light_dark_q),
    .light_bright_i (light_bright_q),
    .lux_cfg_i      (lux_cfg_q),
    .light_cal_i    (light_cal_q),
    .out_valid_o    (vld[0]),
    .out_ready_i    (rdy[0]),
    .out_o          (st[0])
  );

  for (genvar i = 0; i < NumBits; i++) begin : g_cell
    tpsl_cell u_cell (
      .clk_i,
      .rst_ni,
      .in_valid_i  (vld[i]),
      .in_ready_o  (rdy[i]),
      .in_i        (st[i]),
      .out_valid_o (vld[i+1]),
      .out_ready_i (rdy[i+1]),
      .out_o       (st[i+1])
    );
  end

  tpsl_back u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i  (vld[NumBits]),
    .in_ready_o  (rdy[NumBits]),
    .in_i        (st[NumBits]),
    .lux_cfg_i   (lux_cfg_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .moist_o     (moist),
    .lux_o       (lux)
  );

  assign m_axis_tdata = {{(OutDataBits-MoistBits-LuxBits){1'b0}}, lux, moist};

endmodule
`default_nettype wire

/* hw/rtl/tpsl_checker.sv */
// tpsl_checker: port-level assertions for the sensor linearizer, bound to the top level
// depends on tpsl_pkg and two_point_sensor_linearizer
`timescale 1ns / 1ps
`default_nettype none
module tpsl_checker import tpsl_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OutDataBits-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item dropped or changed while stalled");

  a_moist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[MoistBits-1:0] <= MoistMax)
    else $error("moisture above full scale");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_no_early_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output item right after reset");

endmodule

bind two_point_sensor_linearizer tpsl_checker u_tpsl_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);
`default_nettype wire
